// ===== src/checked_rpn_expression_evaluator_core_defines.svh =====
// Assertion macros shared by the evaluator RTL.
// Included by the modules that carry concurrent checks; no other dependency.
`ifndef CHECKED_RPN_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define CHECKED_RPN_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
// Implication check, disabled in reset.
`define RPN_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication check, disabled in reset.
`define RPN_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== src/crpn_pkg.sv =====
// Package for the checked RPN evaluator: command and status codes, types.
// No dependencies; used by every RTL module of the block.
`default_nettype none
package crpn_pkg;
  localparam int unsigned WordW = 64;
  localparam int unsigned CmdW = 3;
  localparam int unsigned StatW = 4;
  localparam int unsigned CfgIdxW = 3;

  localparam logic [CmdW-1:0] CMD_PUSH_SYM = 3'd0;
  localparam logic [CmdW-1:0] CMD_PUSH_CONST = 3'd1;
  localparam logic [CmdW-1:0] CMD_PUSH_DIM = 3'd2;
  localparam logic [CmdW-1:0] CMD_ADD = 3'd3;
  localparam logic [CmdW-1:0] CMD_SUB = 3'd4;
  localparam logic [CmdW-1:0] CMD_MUL = 3'd5;
  localparam logic [CmdW-1:0] CMD_FDIV = 3'd6;
  localparam logic [CmdW-1:0] CMD_MOD = 3'd7;

  localparam logic [StatW-1:0] ST_OK = 4'd0;
  localparam logic [StatW-1:0] ST_SYM = 4'd1;
  localparam logic [StatW-1:0] ST_DIMPLAN = 4'd2;
  localparam logic [StatW-1:0] ST_DIMIDX = 4'd3;
  localparam logic [StatW-1:0] ST_UNDER = 4'd4;
  localparam logic [StatW-1:0] ST_ADD = 4'd5;
  localparam logic [StatW-1:0] ST_SUB = 4'd6;
  localparam logic [StatW-1:0] ST_MUL = 4'd7;
  localparam logic [StatW-1:0] ST_DIVZ = 4'd8;
  localparam logic [StatW-1:0] ST_DIVOVF = 4'd9;
  localparam logic [StatW-1:0] ST_MODOVF = 4'd10;
  localparam logic [StatW-1:0] ST_SINGLE = 4'd11;
  localparam logic [StatW-1:0] ST_FULL = 4'd12;

  localparam logic [CfgIdxW-1:0] REG_SYM0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SYM1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_SYM2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_SYMCNT = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_COORD0 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_COORD1 = 3'd5;
  localparam logic [CfgIdxW-1:0] REG_COORD2 = 3'd6;
  localparam logic [CfgIdxW-1:0] REG_DIMCTX = 3'd7;

  // Operations of the shared arithmetic unit.
  typedef enum logic [1:0] {
    ALU_MUL = 2'd0,
    ALU_DIV = 2'd1
  } alu_op_t;

  // Request and response between the sequencer and the arithmetic unit.
  typedef struct packed {
    logic start;
    alu_op_t op;
  } alu_req_t;

  typedef struct packed {
    logic done;
    logic ovf;
  } alu_rsp_t;
endpackage
`default_nettype wire

// ===== src/crpn_alu.sv =====
// Shared iterative multiply / divide unit on 64-bit magnitudes, one bit a cycle.
// Depends on crpn_pkg. Multiply flags a product above 64 bits; divide floors nothing.
`default_nettype none
module crpn_alu
  import crpn_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire alu_req_t         req,
  input  wire logic [WordW-1:0] opa,
  input  wire logic [WordW-1:0] opb,
  output alu_rsp_t              rsp,
  output logic      [WordW-1:0] res,
  output logic      [WordW-1:0] rem
);
  localparam int unsigned CntW = $clog2(WordW) + 1;

  logic             busy;
  alu_op_t          op;
  logic [CntW-1:0]  cnt;
  logic [WordW-1:0] acc;
  logic [WordW-1:0] sh;
  logic [WordW-1:0] dvs;
  logic             ovf;
  logic             done;
  logic [WordW:0]   trial;
  logic [WordW:0]   madd;

  // Division: shift one dividend bit into the remainder and try a subtract.
  assign trial = {acc, sh[WordW-1]} - {1'b0, dvs};
  // Multiply: MSB-first shift-add, overflow once bit 63 would shift out.
  assign madd = {acc, 1'b0} + (sh[WordW-1] ? {1'b0, dvs} : '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CntW'(WordW);
        op <= req.op;
        acc <= '0;
        sh <= opa;
        dvs <= opb;
        ovf <= 1'b0;
      end else if (busy) begin
        if (op == ALU_MUL) begin
          if (acc[WordW-1] || madd[WordW]) ovf <= 1'b1;
          acc <= madd[WordW-1:0];
        end else begin
          if (!trial[WordW]) acc <= trial[WordW-1:0];
          else acc <= {acc[WordW-2:0], sh[WordW-1]};
        end
        sh <= {sh[WordW-2:0], (op == ALU_DIV) ? !trial[WordW] : 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.ovf = ovf;
  assign res = (op == ALU_MUL) ? acc : sh;
  assign rem = acc;
endmodule
`default_nettype wire

// ===== src/crpn_stack.sv =====
// Operand stack memory: one write port, one registered read port.
// Depends on crpn_pkg for the word width.
`default_nettype none
module crpn_stack
  import crpn_pkg::*;
#(
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(Depth)-1:0] waddr,
  input  wire logic [WordW-1:0]         wdata,
  input  wire logic [$clog2(Depth)-1:0] raddr,
  output logic      [WordW-1:0]         rdata
);
  logic [WordW-1:0] mem [Depth];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== src/checked_rpn_expression_evaluator_core.sv =====
// Top level of the checked RPN expression evaluator: sequencer, config registers.
// Depends on crpn_pkg, crpn_stack, crpn_alu and the assertion macro header.
//
// The evaluator takes one token beat at a time and answers each token marked
// last with one result beat (value and status). A push passes through S_EXEC
// and S_FIN; a token skipped after an earlier error, or one that underflows,
// goes straight to S_FIN. Add and subtract pass through S_RDB, S_RDA, S_EXEC,
// S_WAIT and S_FIN, since both operands are read one after the other from the
// single read port of the stack memory. Multiply and floor division wait in
// S_WAIT for the shared one-bit-a-cycle multiply/divide unit. A division by
// zero or a division overflow is caught in S_EXEC before the unit starts.
// Modulo runs a division and then a multiply.
// The bottom stack entry is mirrored in a register, so a token marked last needs
// no extra read. The token input is stalled while a token is in work. A result
// beat that waits to be taken holds the block only once the next token marked
// last is ready to answer. Configuration writes are taken at any time but are
// meant for idle periods. There is no clearing pass: stack entries above the
// fill are never used.
`default_nettype none
`include "checked_rpn_expression_evaluator_core_defines.svh"
module checked_rpn_expression_evaluator_core
  import crpn_pkg::*;
#(
  parameter int unsigned STACK_DEPTH = 16,
  parameter int unsigned NUM_SYMBOLS = 3,
  parameter int unsigned NUM_DIMS = 3
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [WordW-1:0]    cfg_data,
  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [CmdW-1:0]     command,
  input  wire logic signed [WordW-1:0] operand,
  input  wire logic                last,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [WordW-1:0]  value,
  output logic      [StatW-1:0]    status
);
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned FW = $clog2(STACK_DEPTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_RDB   = 9'b000000010,
    S_RDA   = 9'b000000100,
    S_EXEC  = 9'b000001000,
    S_WAIT  = 9'b000010000,
    S_MODM  = 9'b000100000,
    S_MODW  = 9'b001000000,
    S_FIN   = 9'b010000000,
    S_FINRD = 9'b100000000
  } state_t;

  state_t state;
  logic [WordW-1:0] sym_reg [3];
  logic [WordW-1:0] crd_reg [3];
  logic [1:0] sym_cnt;
  logic [2:0] dim_ctx;
  logic [FW-1:0] fill;
  logic [StatW-1:0] err;
  logic [CmdW-1:0] cmd;
  logic [WordW-1:0] opnd;
  logic is_last;
  logic [WordW-1:0] a, b, q;
  logic neg;
  logic [WordW-1:0] bottom;

  logic we;
  logic [AW-1:0] waddr, raddr;
  logic [WordW-1:0] wdata, rdata;
  alu_req_t req;
  alu_rsp_t rsp;
  logic [WordW-1:0] alu_a, alu_b, alu_res, alu_rem;

  crpn_stack #(.Depth(STACK_DEPTH)) u_stack (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );
  crpn_alu u_alu (
    .clk(clk), .rst(rst), .req(req), .opa(alu_a), .opb(alu_b),
    .rsp(rsp), .res(alu_res), .rem(alu_rem)
  );

  function automatic logic [WordW-1:0] mag(input logic [WordW-1:0] v);
    mag = v[WordW-1] ? (~v + 1'b1) : v;
  endfunction

  // Index checks for pushes: the index must be non-negative and below the limit.
  logic [1:0] sym_lim, dim_lim;
  logic sym_ok, dim_ok;
  logic [2:0] dim_raw;
  always_comb begin
    sym_lim = (sym_cnt < 2'(NUM_SYMBOLS)) ? sym_cnt : 2'(NUM_SYMBOLS);
    dim_raw = dim_ctx - 3'd1;
    dim_lim = (dim_raw > 3'(NUM_DIMS)) ? 2'(NUM_DIMS) : dim_raw[1:0];
    sym_ok = (opnd[WordW-1:2] == '0) && (opnd[1:0] < sym_lim);
    dim_ok = (opnd[WordW-1:2] == '0) && (opnd[1:0] < dim_lim);
  end

  // Arithmetic on the two popped operands.
  logic [WordW-1:0] sum, dif, sgnres, modr;
  logic add_ovf, sub_ovf, sgn_ovf, mod_ovf, rem_nz;
  always_comb begin
    sum = a + b;
    dif = a - b;
    add_ovf = (a[WordW-1] == b[WordW-1]) && (sum[WordW-1] != a[WordW-1]);
    sub_ovf = (a[WordW-1] != b[WordW-1]) && (dif[WordW-1] != a[WordW-1]);
    // Sign-apply the unit's magnitude result; overflow past the signed range.
    sgnres = neg ? (~alu_res + 1'b1) : alu_res;
    sgn_ovf = neg ? (alu_res > {1'b1, {(WordW-1){1'b0}}})
                  : alu_res[WordW-1];
    rem_nz = (alu_rem != '0);
    modr = a - q;
    mod_ovf = (a[WordW-1] != q[WordW-1]) && (modr[WordW-1] != a[WordW-1]);
  end

  logic [WordW-1:0] qfl;
  assign qfl = (neg && rem_nz) ? (sgnres - 1'b1) : sgnres;

  // The unit starts from S_EXEC, where the lower operand is still on the read
  // port, or from S_MODM for the quotient times divisor product.
  always_comb begin
    alu_a = (state == S_MODM) ? mag(q) : mag(rdata);
    alu_b = mag(b);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sym_reg[0] <= '0; sym_reg[1] <= '0; sym_reg[2] <= '0;
      crd_reg[0] <= '0; crd_reg[1] <= '0; crd_reg[2] <= '0;
      sym_cnt <= '0;
      dim_ctx <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SYM0: sym_reg[0] <= cfg_data;
        REG_SYM1: sym_reg[1] <= cfg_data;
        REG_SYM2: sym_reg[2] <= cfg_data;
        REG_SYMCNT: sym_cnt <= cfg_data[1:0];
        REG_COORD0: crd_reg[0] <= cfg_data;
        REG_COORD1: crd_reg[1] <= cfg_data;
        REG_COORD2: crd_reg[2] <= cfg_data;
        REG_DIMCTX: dim_ctx <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  logic push_req;
  logic [WordW-1:0] push_val;
  logic [StatW-1:0] tok_err;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill <= '0;
      err <= ST_OK;
      out_valid <= 1'b0;
    end else begin
      // A waiting beat that is taken while the next answer loads is replaced below.
      if (out_valid && !out_stall && !(state == S_FIN && is_last)) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            cmd <= command;
            opnd <= operand;
            is_last <= last;
            if (err != ST_OK) begin
              state <= S_FIN;
            end else if (command >= CMD_ADD) begin
              if (fill < FW'(2)) begin
                err <= ST_UNDER;
                state <= S_FIN;
              end else begin
                state <= S_RDB;
              end
            end else begin
              state <= S_EXEC;
            end
          end
        end
        S_RDB: begin
          b <= rdata;
          state <= S_RDA;
        end
        S_RDA: state <= S_EXEC;
        S_EXEC: begin
          if (cmd < CMD_ADD) begin
            if (tok_err != ST_OK) err <= tok_err;
            else fill <= fill + 1'b1;
            state <= S_FIN;
          end else begin
            a <= rdata;
            fill <= fill - FW'(2);
            neg <= rdata[WordW-1] ^ b[WordW-1];
            if ((cmd == CMD_FDIV || cmd == CMD_MOD) && b == '0) begin
              err <= ST_DIVZ;
              state <= S_FIN;
            end else if ((cmd == CMD_FDIV || cmd == CMD_MOD) &&
                         rdata == {1'b1, {(WordW-1){1'b0}}} && b == '1) begin
              err <= ST_DIVOVF;
              state <= S_FIN;
            end else begin
              state <= S_WAIT;
            end
          end
        end
        S_WAIT: begin
          if (cmd == CMD_ADD || cmd == CMD_SUB) begin
            state <= S_FIN;
            if (tok_err != ST_OK) err <= tok_err;
            else if (fill < FW'(STACK_DEPTH)) fill <= fill + 1'b1;
            else err <= ST_FULL;
          end else if (rsp.done) begin
            if (cmd == CMD_MUL) begin
              state <= S_FIN;
              if (rsp.ovf || sgn_ovf) err <= ST_MUL;
              else fill <= fill + 1'b1;
            end else if (cmd == CMD_FDIV) begin
              state <= S_FIN;
              fill <= fill + 1'b1;
            end else begin
              q <= qfl;
              neg <= qfl[WordW-1] ^ b[WordW-1];
              state <= S_MODM;
            end
          end
        end
        S_MODM: state <= S_MODW;
        S_MODW: begin
          if (rsp.done) begin
            q <= sgnres;
            state <= (rsp.ovf || sgn_ovf) ? S_FIN : S_FINRD;
            if (rsp.ovf || sgn_ovf) err <= ST_MODOVF;
          end
        end
        S_FINRD: begin
          state <= S_FIN;
          if (mod_ovf) err <= ST_MODOVF;
          else fill <= fill + 1'b1;
        end
        S_FIN: begin
          if (!is_last) begin
            state <= S_IDLE;
          end else if (!out_valid || !out_stall) begin
            out_valid <= 1'b1;
            status <= (err != ST_OK) ? err : ((fill != FW'(1)) ? ST_SINGLE : ST_OK);
            value <= (err == ST_OK && fill == FW'(1)) ? bottom : '0;
            fill <= '0;
            err <= ST_OK;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Token error for pushes and add/sub, evaluated with the captured token.
  always_comb begin
    tok_err = ST_OK;
    push_val = opnd;
    case (cmd)
      CMD_PUSH_SYM: begin
        push_val = sym_reg[opnd[1:0]];
        if (!sym_ok) tok_err = ST_SYM;
      end
      CMD_PUSH_DIM: begin
        push_val = crd_reg[opnd[1:0]];
        if (dim_ctx == 3'd0) tok_err = ST_DIMPLAN;
        else if (!dim_ok) tok_err = ST_DIMIDX;
      end
      CMD_ADD: if (add_ovf) tok_err = ST_ADD;
      CMD_SUB: if (sub_ovf) tok_err = ST_SUB;
      default: ;
    endcase
    if (state == S_EXEC && cmd < CMD_ADD && tok_err == ST_OK && fill >= FW'(STACK_DEPTH))
      tok_err = ST_FULL;
  end

  // Stack write of the token result and read address sequencing.
  always_comb begin
    we = 1'b0;
    wdata = push_val;
    waddr = fill[AW-1:0];
    push_req = 1'b0;
    if (state == S_EXEC && cmd < CMD_ADD && tok_err == ST_OK) push_req = 1'b1;
    if (state == S_WAIT) begin
      case (cmd)
        CMD_ADD: begin wdata = sum; push_req = !add_ovf; end
        CMD_SUB: begin wdata = dif; push_req = !sub_ovf; end
        CMD_MUL: begin wdata = sgnres; push_req = rsp.done && !(rsp.ovf || sgn_ovf); end
        CMD_FDIV: begin wdata = qfl; push_req = rsp.done; end
        default: ;
      endcase
    end
    if (state == S_FINRD) begin
      wdata = modr;
      push_req = !mod_ovf;
    end
    we = push_req && (fill < FW'(STACK_DEPTH));
    // The top entry is read at acceptance, the one below it in S_RDA.
    raddr = '0;
    if (state == S_IDLE) raddr = AW'(fill - FW'(1));
    else if (state == S_RDA) raddr = AW'(fill - FW'(2));
  end

  // Copy of the bottom entry, which is the answer when one value remains.
  always_ff @(posedge clk) begin
    if (we && waddr == '0) bottom <= wdata;
  end

  assign req.start = (state == S_EXEC && (cmd == CMD_MUL ||
                      ((cmd == CMD_FDIV || cmd == CMD_MOD) && b != '0 &&
                       !(rdata == {1'b1, {(WordW-1){1'b0}}} && b == '1)))) ||
                     (state == S_MODM);
  assign req.op = (state == S_EXEC && cmd != CMD_MUL) ? ALU_DIV : ALU_MUL;

  assign in_stall = (state != S_IDLE);

  `RPN_ASSERT_IMP(a_fill_bound, clk, rst, 1'b1, fill <= FW'(STACK_DEPTH), "fill above depth")
  `RPN_ASSERT_NEXT(a_out_clears, clk, rst, out_valid && !out_stall && state != S_FIN,
    !out_valid, "result beat repeated")
  `RPN_ASSERT_IMP(a_busy_stalls, clk, rst, state != S_IDLE, in_stall, "input taken while busy")
endmodule
`default_nettype wire
